### sv/ipse_pkg.sv
// Shared types and constants for the indexed pixel shade enhancer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ipse_pkg;

  // Default frame geometry.
  localparam int unsigned FRAME_WIDTH_DEF  = 320;
  localparam int unsigned FRAME_HEIGHT_DEF = 200;

  // Field widths of the stream items.
  localparam int unsigned X_W      = 9;
  localparam int unsigned Y_W      = 8;
  localparam int unsigned PIXEL_W  = 8;
  localparam int unsigned COLOR_W  = 4;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned SHADE_W  = 4;
  localparam int unsigned COORD_W  = 11;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 16;

  // Shade arithmetic constants.
  localparam int unsigned SHADE_NEUTRAL = 8;
  localparam int unsigned SHADE_MAX     = 15;
  localparam int unsigned EDGE_DROP     = 2;
  localparam int unsigned RUN_MIN_D     = 3;

  // Operation carried in tuser.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  // Moves of the shared address stepper.
  typedef enum logic [1:0] {
    STEP_UP    = 2'd0,
    STEP_DOWN  = 2'd1,
    STEP_LEFT  = 2'd2,
    STEP_RIGHT = 2'd3
  } step_e;

  // Neighborhood facts gathered by the sequencer for the shade unit.
  typedef struct packed {
    logic has_up;
    logic has_down;
    logic side_diff;
  } nb_flags_t;

endpackage

`default_nettype wire

### sv/ipse_frame_mem.sv
// Frame store of 4-bit colours: one write port and one registered read port.
// Depends on ipse_pkg for the colour width.
`default_nettype none

module ipse_frame_mem #(
  parameter int unsigned DEPTH = ipse_pkg::FRAME_WIDTH_DEF * ipse_pkg::FRAME_HEIGHT_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [AW-1:0]                waddr_i,
  input  wire logic [ipse_pkg::COLOR_W-1:0] wdata_i,
  input  wire logic [AW-1:0]                raddr_i,
  output logic      [ipse_pkg::COLOR_W-1:0] rdata_o
);

  logic [ipse_pkg::COLOR_W-1:0] mem [DEPTH];
  logic [ipse_pkg::COLOR_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered data, read every cycle.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/ipse_addr_step.sv
// Shared address stepper: moves a frame address by one row or one column.
// Depends on ipse_pkg for the step codes.
`default_nettype none

module ipse_addr_step #(
  parameter int unsigned FRAME_WIDTH = ipse_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned AW          = 16
) (
  input  wire logic [AW-1:0]         base_i,
  input  wire ipse_pkg::step_e       op_i,
  output logic      [AW-1:0]         addr_o
);

  localparam logic [AW-1:0] ROW_STEP = AW'(FRAME_WIDTH);
  localparam logic [AW-1:0] COL_STEP = AW'(1);

  // One adder serves every move of the column walk and the side checks.
  always_comb begin
    unique case (op_i)
      ipse_pkg::STEP_UP:    addr_o = base_i - ROW_STEP;
      ipse_pkg::STEP_DOWN:  addr_o = base_i + ROW_STEP;
      ipse_pkg::STEP_LEFT:  addr_o = base_i - COL_STEP;
      ipse_pkg::STEP_RIGHT: addr_o = base_i + COL_STEP;
      default:              addr_o = base_i;
    endcase
  end

endmodule

`default_nettype wire

### sv/ipse_shade.sv
// Shade computation from the vertical run counts and the neighborhood flags.
// Depends on ipse_pkg for constants and the flag struct.
`default_nettype none

module ipse_shade #(
  parameter int unsigned RW = 8
) (
  input  wire logic [ipse_pkg::COLOR_W-1:0] base_i,
  input  wire logic [RW-1:0]                up_i,
  input  wire logic [RW-1:0]                down_i,
  input  wire ipse_pkg::nb_flags_t          flags_i,
  output logic      [ipse_pkg::INDEX_W-1:0] index_o,
  output logic      [ipse_pkg::SHADE_W-1:0] shade_o
);

  localparam int unsigned SW = RW + 3;

  logic [SW-1:0]      d;
  logic [SW-1:0]      d2;
  logic [SW-1:0]      d3;
  logic [SW-1:0]      up4;
  logic [SW-1:0]      mag;
  logic [SW-1:0]      mag2;
  logic               neg;
  logic               long_run;
  logic               edge_hit;
  logic [1:0]         quot;
  logic signed [5:0]  shade_s;

  // Span d = up + down; the ratio (2d - 4up)/d lies in -2..2, so the
  // rounded quotient comes from two compares instead of a divider.
  always_comb begin
    d        = SW'(up_i) + SW'(down_i);
    d2       = d << 1;
    d3       = d + d2;
    up4      = SW'(up_i) << 2;
    neg      = up4 > d2;
    mag      = neg ? (up4 - d2) : (d2 - up4);
    mag2     = mag << 1;
    long_run = d >= SW'(ipse_pkg::RUN_MIN_D);
    if (mag2 >= d3) begin
      quot = 2'd2;
    end else if (mag2 >= d) begin
      quot = 2'd1;
    end else begin
      quot = 2'd0;
    end
  end

  // An edge is any in-frame 4-neighbor of another colour.
  assign edge_hit = flags_i.side_diff
                  | (flags_i.has_up   && (up_i   == '0))
                  | (flags_i.has_down && (down_i == '0));

  // Assemble, drop at edges and clamp.
  always_comb begin
    shade_s = 6'(ipse_pkg::SHADE_NEUTRAL);
    if (base_i != '0) begin
      if (long_run) begin
        shade_s = neg ? (shade_s - $signed({4'd0, quot})) : (shade_s + $signed({4'd0, quot}));
      end
      if (edge_hit) begin
        shade_s = shade_s - 6'(ipse_pkg::EDGE_DROP);
      end
      if (shade_s < 6'sd0) begin
        shade_s = 6'sd0;
      end else if (shade_s > 6'(ipse_pkg::SHADE_MAX)) begin
        shade_s = 6'(ipse_pkg::SHADE_MAX);
      end
    end
    shade_o = shade_s[ipse_pkg::SHADE_W-1:0];
    index_o = {base_i, shade_o};
  end

endmodule

`default_nettype wire

### sv/indexed_pixel_shade_enhancer.sv
// Indexed pixel shade enhancer: top level with the query sequencer.
// Depends on ipse_pkg, ipse_frame_mem, ipse_addr_step and ipse_shade.
//
// Usage: items enter on the s_axis channel. tuser carries the opcode (write
// or query); tdata carries x, y and the pixel byte. A write stores the low
// nibble of the pixel at (x,y) and gives no result. A query gives one
// result on m_axis: the colour index and the shade level. Items with
// coordinates outside the frame are dropped without a result. The frame is
// loaded before it is queried.
// Steps: an accepted item is registered and its range is checked; an item
// outside the frame ends there, and a write then stores its pixel. A query
// reads the center pixel and ends there if it is black. Otherwise it walks
// up and then down the column while the colour matches, counting up and
// down, the same-colour runs above and below, then reads each side neighbor
// in the frame. The frame store has a single read port: one pixel per cycle.
// s_axis_tready is high only while the sequencer is idle. A finished result
// sits in an output register, so the next item is accepted while the
// receiver stalls; a second result waits in the sequencer until the
// register is free. Reset clears the control state; the frame store is not
// cleared and holds undefined values until written.
`default_nettype none

module indexed_pixel_shade_enhancer #(
  parameter int unsigned FRAME_WIDTH  = ipse_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = ipse_pkg::FRAME_HEIGHT_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tuser: opcode [0]
  input  wire logic                              s_axis_tuser,
  // tdata: x [8:0], y [16:9], pixel [24:17], zero fill [31:25]
  input  wire logic [ipse_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata: colour_index [7:0], shade_level [11:8], zero fill [15:12]
  output logic      [ipse_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = $clog2(FRAME_HEIGHT + 1);
  localparam int unsigned CW    = ipse_pkg::COORD_W;
  localparam int unsigned XW    = ipse_pkg::X_W;
  localparam int unsigned YW    = ipse_pkg::Y_W;
  localparam int unsigned PW    = ipse_pkg::PIXEL_W;
  localparam int unsigned KW    = ipse_pkg::COLOR_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WRITE,
    ST_CENTER,
    ST_UP,
    ST_DSTART,
    ST_DOWN,
    ST_LSTART,
    ST_LEFT,
    ST_RSTART,
    ST_RIGHT,
    ST_FIN
  } state_e;

  state_e                        state_q, state_d;
  ipse_pkg::opcode_e             op_q, op_d;
  logic [XW-1:0]                 x_q, x_d;
  logic [YW-1:0]                 y_q, y_d;
  logic [KW-1:0]                 pix_q, pix_d;
  logic [AW-1:0]                 addr_q, addr_d;
  logic [AW-1:0]                 ctr_q, ctr_d;
  logic [RW-1:0]                 row_q, row_d;
  logic [RW-1:0]                 up_q, up_d;
  logic [RW-1:0]                 down_q, down_d;
  logic [KW-1:0]                 base_q, base_d;
  logic                          side_q, side_d;
  logic                          out_valid_q, out_valid_d;
  logic [ipse_pkg::INDEX_W-1:0]  out_idx_q, out_idx_d;
  logic [ipse_pkg::SHADE_W-1:0]  out_shade_q, out_shade_d;

  logic [KW-1:0]                 rd_data;
  logic [AW-1:0]                 step_base;
  ipse_pkg::step_e               step_op;
  logic [AW-1:0]                 step_addr;
  logic [AW-1:0]                 ctr_calc;
  logic                          in_range;
  logic                          has_up;
  logic                          has_down;
  logic                          has_left;
  logic                          has_right;
  logic                          row_more;
  logic                          match;
  ipse_pkg::nb_flags_t           flags;
  logic [ipse_pkg::INDEX_W-1:0]  calc_idx;
  logic [ipse_pkg::SHADE_W-1:0]  calc_shade;

  // Frame store.
  ipse_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_WRITE),
    .waddr_i (addr_q),
    .wdata_i (pix_q),
    .raddr_i (addr_d),
    .rdata_o (rd_data)
  );

  // Shared address stepper.
  ipse_addr_step #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .AW          (AW)
  ) u_step (
    .base_i (step_base),
    .op_i   (step_op),
    .addr_o (step_addr)
  );

  // Shade arithmetic.
  ipse_shade #(
    .RW (RW)
  ) u_shade (
    .base_i  (base_q),
    .up_i    (up_q),
    .down_i  (down_q),
    .flags_i (flags),
    .index_o (calc_idx),
    .shade_o (calc_shade)
  );

  // Position facts about the registered item.
  assign in_range  = ({{(CW-XW){1'b0}}, x_q} < CW'(FRAME_WIDTH))
                  && ({{(CW-YW){1'b0}}, y_q} < CW'(FRAME_HEIGHT));
  assign has_up    = (y_q != '0);
  assign has_down  = (({{(CW-YW){1'b0}}, y_q} + CW'(1)) < CW'(FRAME_HEIGHT));
  assign has_left  = (x_q != '0);
  assign has_right = (({{(CW-XW){1'b0}}, x_q} + CW'(1)) < CW'(FRAME_WIDTH));
  assign row_more  = ((row_q + RW'(1)) < RW'(FRAME_HEIGHT));
  assign ctr_calc  = AW'(y_q) * AW'(FRAME_WIDTH) + AW'(x_q);
  assign match     = (rd_data == base_q);

  assign flags.has_up    = has_up;
  assign flags.has_down  = has_down;
  assign flags.side_diff = side_q;

  // The stepper walks from the current address along the column and from
  // the center for every fresh start.
  always_comb begin
    step_base = ctr_q;
    step_op   = ipse_pkg::STEP_UP;
    unique case (state_q)
      ST_CENTER: step_op = ipse_pkg::STEP_UP;
      ST_UP: begin
        step_base = addr_q;
        step_op   = ipse_pkg::STEP_UP;
      end
      ST_DSTART: step_op = ipse_pkg::STEP_DOWN;
      ST_DOWN: begin
        step_base = addr_q;
        step_op   = ipse_pkg::STEP_DOWN;
      end
      ST_LSTART: step_op = ipse_pkg::STEP_LEFT;
      ST_RSTART: step_op = ipse_pkg::STEP_RIGHT;
      default: step_op = ipse_pkg::STEP_UP;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    x_d         = x_q;
    y_d         = y_q;
    pix_d       = pix_q;
    addr_d      = addr_q;
    ctr_d       = ctr_q;
    row_d       = row_q;
    up_d        = up_q;
    down_d      = down_q;
    base_d      = base_q;
    side_d      = side_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    out_shade_d = out_shade_q;

    // The receiver takes the pending result.
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = ipse_pkg::opcode_e'(s_axis_tuser);
          x_d     = s_axis_tdata[XW-1:0];
          y_d     = s_axis_tdata[XW+YW-1:XW];
          pix_d   = s_axis_tdata[XW+YW+KW-1:XW+YW];
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        addr_d = ctr_calc;
        ctr_d  = ctr_calc;
        if (!in_range) begin
          state_d = ST_IDLE;
        end else if (op_q == ipse_pkg::OP_WRITE) begin
          state_d = ST_WRITE;
        end else begin
          state_d = ST_CENTER;
        end
      end
      ST_WRITE: state_d = ST_IDLE;
      ST_CENTER: begin
        base_d = rd_data;
        up_d   = '0;
        down_d = '0;
        side_d = 1'b0;
        if (rd_data == '0) begin
          state_d = ST_FIN;
        end else if (has_up) begin
          addr_d  = step_addr;
          row_d   = RW'(y_q - YW'(1));
          state_d = ST_UP;
        end else begin
          state_d = ST_DSTART;
        end
      end
      ST_UP: begin
        if (match) begin
          up_d = up_q + RW'(1);
          if (row_q != '0) begin
            addr_d = step_addr;
            row_d  = row_q - RW'(1);
          end else begin
            state_d = ST_DSTART;
          end
        end else begin
          state_d = ST_DSTART;
        end
      end
      ST_DSTART: begin
        if (has_down) begin
          addr_d  = step_addr;
          row_d   = RW'(y_q) + RW'(1);
          state_d = ST_DOWN;
        end else begin
          state_d = ST_LSTART;
        end
      end
      ST_DOWN: begin
        if (match) begin
          down_d = down_q + RW'(1);
          if (row_more) begin
            addr_d = step_addr;
            row_d  = row_q + RW'(1);
          end else begin
            state_d = ST_LSTART;
          end
        end else begin
          state_d = ST_LSTART;
        end
      end
      ST_LSTART: begin
        if (has_left) begin
          addr_d  = step_addr;
          state_d = ST_LEFT;
        end else begin
          state_d = ST_RSTART;
        end
      end
      ST_LEFT: begin
        side_d  = side_q | !match;
        state_d = ST_RSTART;
      end
      ST_RSTART: begin
        if (has_right) begin
          addr_d  = step_addr;
          state_d = ST_RIGHT;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_RIGHT: begin
        side_d  = side_q | !match;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_idx_d   = calc_idx;
          out_shade_d = calc_shade;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    x_q         <= x_d;
    y_q         <= y_d;
    pix_q       <= pix_d;
    addr_q      <= addr_d;
    ctr_q       <= ctr_d;
    row_q       <= row_d;
    up_q        <= up_d;
    down_q      <= down_d;
    base_q      <= base_d;
    side_q      <= side_d;
    out_idx_q   <= out_idx_d;
    out_shade_q <= out_shade_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(ipse_pkg::OUT_TDATA_W - ipse_pkg::INDEX_W - ipse_pkg::SHADE_W){1'b0}},
                          out_shade_q, out_idx_q};

  // Unused bits of the input transaction: the zero fill and the pixel's high nibble.
  logic unused_fill;
  assign unused_fill = ^{s_axis_tdata[ipse_pkg::IN_TDATA_W-1:XW+YW+KW],
                         s_axis_tdata[XW+YW+PW-1:XW+YW+KW]};

endmodule

`default_nettype wire

### sv/ipse_checker.sv
// Port-level assertions for the indexed pixel shade enhancer.
// Depends on ipse_pkg; bound to the top level at the end of this file.
`default_nettype none

module ipse_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              s_axis_tuser,
  input wire logic [ipse_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [ipse_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The sequencer is busy right after taking a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after a transaction");

  // The index carries the same shade as the shade field, with zero fill.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[3:0] == m_axis_tdata[11:8])
                   && (m_axis_tdata[15:12] == 4'd0))
    else $error("index and shade disagree");

  // Black always gives the neutral shade.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[7:4] == 4'd0)
      |-> m_axis_tdata[11:8] == 4'(ipse_pkg::SHADE_NEUTRAL))
    else $error("black pixel with a shade other than neutral");

  // Other colours move at most two levels up and four down.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[7:4] != 4'd0)
      |-> (m_axis_tdata[11:8] >= 4'd4) && (m_axis_tdata[11:8] <= 4'd10))
    else $error("shade out of its reachable range");

  // Input payload is only observed through the handshake here.
  logic unused_in;
  assign unused_in = ^{s_axis_tuser, s_axis_tdata};

endmodule

bind indexed_pixel_shade_enhancer ipse_checker u_ipse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
